[hdl/tsc_pkg.sv]
// ----------------------------------------------------------------------------
// tsc_pkg
// Shared types and constants of the tick timekeeper: state encoding, unit
// request bundles and fixed arithmetic widths.
// ----------------------------------------------------------------------------
package tsc_pkg;

   localparam int unsigned WORD_W = 32;
   localparam int unsigned NSEC_W = 30;

   // ns accumulator: nsec + offset * 1000 stays below 2^42
   localparam int unsigned ACC_W  = 42;
   // whole seconds carried out of one tick stay below 2^13
   localparam int unsigned SECQ_W = 13;
   // bits of the microsecond-to-nanosecond factor
   localparam int unsigned USK_W  = 10;

   localparam logic [USK_W-1:0] NS_PER_US  = 10'd1000;
   localparam logic [ACC_W-1:0] NS_PER_SEC = 42'd1000000000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CAL_DIV,
      ST_KHZ_DIV,
      ST_MUL,
      ST_NORM,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic              start;
      logic [WORD_W-1:0] rem_init;
      logic [WORD_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              start;
      logic [WORD_W-1:0] multiplicand;
      logic [WORD_W-1:0] factor;
   } mul_req_type;

   typedef struct packed {
      logic              start;
      logic [WORD_W-1:0] offset;
      logic [NSEC_W-1:0] nsec;
   } norm_req_type;

endpackage

[hdl/tsc_tick_timekeeper.sv]
// ----------------------------------------------------------------------------
// tsc_tick_timekeeper
// Wall-time keeper driven by timestamp-counter readings: calibrates a
// microseconds-per-clock quotient and advances seconds/nanoseconds per tick.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_stall  opcode, first/second lo/hi, polls
//   rsp_      out        rsp_valid/rsp_stall  time, ticks, offset, quotient, kHz, status
//
// Work: a tick runs the serial multiplier, the x1000 scaling and the seconds
//   split, plus handoff; a good calibration runs one or two 32-step serial
//   divisions, the second only for a quotient above 1000; a rejected
//   calibration goes straight to the result. One item is in work at a time.
// Reset: synchronous; clears the controller and all time-keeping state.
// Stalls: req_stall is high while an item is in work. A finished result waits
//   in the output register; a following item is taken meanwhile and only its
//   own result waits on rsp_stall.
// ----------------------------------------------------------------------------
module tsc_tick_timekeeper #(
   parameter int unsigned TICK_HZ = 100
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_opcode,
   input  logic [31:0] req_first_low,
   input  logic [31:0] req_first_high,
   input  logic [31:0] req_second_low,
   input  logic [31:0] req_second_high,
   input  logic [31:0] req_poll_count,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_seconds,
   output logic [29:0] rsp_nanoseconds,
   output logic [31:0] rsp_tick_total,
   output logic [31:0] rsp_offset_us,
   output logic [31:0] rsp_rate_quotient,
   output logic [31:0] rsp_cpu_khz,
   output logic [1:0]  rsp_cal_status
);

   localparam int unsigned W = tsc_pkg::WORD_W;

   // reference interval of the calibration gate, in microseconds
   localparam logic [W-1:0] CAL_TIME_US = W'(5 * 1000020 / TICK_HZ);
   localparam logic [W-1:0] KHZ_SCALE   = W'(1000);
   localparam logic         OP_CAL      = 1'b1;

   localparam logic [1:0] CAL_OK        = 2'd0;
   localparam logic [1:0] CAL_FEW_POLLS = 2'd1;
   localparam logic [1:0] CAL_TOO_FAST  = 2'd2;
   localparam logic [1:0] CAL_TOO_SLOW  = 2'd3;

   tsc_pkg::state_type state_ff, state_in;

   // time-keeping state
   logic [W-1:0]              last_ff, last_in;
   logic [W-1:0]              quot_ff, quot_in;
   logic [W-1:0]              sec_ff, sec_in;
   logic [tsc_pkg::NSEC_W-1:0] nsec_ff, nsec_in;
   logic [W-1:0]              jiffy_ff, jiffy_in;

   // per-item results
   logic [W-1:0] offset_ff, offset_in;
   logic [W-1:0] khz_ff, khz_in;
   logic [1:0]   status_ff, status_in;

   // result register
   logic                       out_valid_ff, out_valid_in;
   logic [W-1:0]               out_sec_ff, out_jiffy_ff, out_offset_ff;
   logic [W-1:0]               out_quot_ff, out_khz_ff;
   logic [tsc_pkg::NSEC_W-1:0] out_nsec_ff;
   logic [1:0]                 out_status_ff;

   logic accept, out_load, out_free;
   logic [63:0] delta;
   logic        few_polls, too_fast, too_slow;
   logic [W-1:0] adv;

   tsc_pkg::div_req_type  div_req;
   tsc_pkg::mul_req_type  mul_req;
   tsc_pkg::norm_req_type norm_req;
   logic                       div_done, mul_done, norm_done;
   logic [W-1:0]               div_quo, mul_hi;
   logic [tsc_pkg::SECQ_W-1:0] norm_carry;
   logic [tsc_pkg::NSEC_W-1:0] norm_nsec;

   assign req_stall = (state_ff != tsc_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !out_valid_ff || !rsp_stall;

   // calibration checks on the raw counter readings
   assign delta     = {req_second_high, req_second_low} - {req_first_high, req_first_low};
   assign few_polls = (req_poll_count <= W'(1));
   assign too_fast  = (delta[63:32] != '0);
   assign too_slow  = (delta[31:0] <= CAL_TIME_US);

   // counter advance since the previous tick, modulo 2^32
   assign adv = req_first_low - last_ff;

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tsc_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_opcode == OP_CAL) begin
                  if (few_polls || too_fast || too_slow) begin
                     state_in = tsc_pkg::ST_DONE;
                  end else begin
                     state_in = tsc_pkg::ST_CAL_DIV;
                  end
               end else begin
                  state_in = tsc_pkg::ST_MUL;
               end
            end
         end
         tsc_pkg::ST_CAL_DIV: begin
            if (div_done) begin
               state_in = (div_quo > KHZ_SCALE) ? tsc_pkg::ST_KHZ_DIV : tsc_pkg::ST_DONE;
            end
         end
         tsc_pkg::ST_KHZ_DIV: begin
            if (div_done) begin
               state_in = tsc_pkg::ST_DONE;
            end
         end
         tsc_pkg::ST_MUL: begin
            if (mul_done) begin
               state_in = tsc_pkg::ST_NORM;
            end
         end
         tsc_pkg::ST_NORM: begin
            if (norm_done) begin
               state_in = tsc_pkg::ST_DONE;
            end
         end
         tsc_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = tsc_pkg::ST_IDLE;
            end
         end
         default: state_in = tsc_pkg::ST_IDLE;
      endcase
   end

   // ------------------------------------------------------- unit starts, loads
   always_comb begin
      div_req  = '0;
      mul_req  = '0;
      norm_req = '0;
      out_load = 1'b0;
      unique case (state_ff)
         tsc_pkg::ST_IDLE: begin
            // quotient = (CAL_TIME_US << 32) / delta
            div_req.rem_init = CAL_TIME_US;
            div_req.divisor  = delta[31:0];
            div_req.start    = accept && (req_opcode == OP_CAL)
                               && !few_polls && !too_fast && !too_slow;
            mul_req.multiplicand = adv;
            mul_req.factor       = quot_ff;
            mul_req.start        = accept && (req_opcode != OP_CAL);
         end
         tsc_pkg::ST_CAL_DIV: begin
            // kHz = (1000 << 32) / quotient; saturates when 0 < quotient <= 1000, zero for a zero quotient
            div_req.rem_init = KHZ_SCALE;
            div_req.divisor  = div_quo;
            div_req.start    = div_done && (div_quo > KHZ_SCALE);
         end
         tsc_pkg::ST_MUL: begin
            norm_req.offset = mul_hi;
            norm_req.nsec   = nsec_ff;
            norm_req.start  = mul_done;
         end
         tsc_pkg::ST_DONE: begin
            out_load = out_free;
         end
         default: begin
         end
      endcase
   end

   // --------------------------------------------------------------- datapath
   always_comb begin
      last_in   = last_ff;
      quot_in   = quot_ff;
      sec_in    = sec_ff;
      nsec_in   = nsec_ff;
      jiffy_in  = jiffy_ff;
      offset_in = offset_ff;
      khz_in    = khz_ff;
      status_in = status_ff;

      if (accept) begin
         last_in   = req_second_low;
         offset_in = '0;
         khz_in    = '0;
         status_in = CAL_OK;
         if (req_opcode == OP_CAL) begin
            if (few_polls) begin
               quot_in   = '0;
               status_in = CAL_FEW_POLLS;
            end else if (too_fast) begin
               quot_in   = '0;
               status_in = CAL_TOO_FAST;
            end else if (too_slow) begin
               quot_in   = '0;
               status_in = CAL_TOO_SLOW;
            end
         end else begin
            jiffy_in = jiffy_ff + 1'b1;
         end
      end

      if (state_ff == tsc_pkg::ST_CAL_DIV && div_done) begin
         quot_in = div_quo;
         if (div_quo == '0) begin
            khz_in = '0;
         end else if (div_quo <= KHZ_SCALE) begin
            khz_in = '1;
         end
      end

      if (state_ff == tsc_pkg::ST_KHZ_DIV && div_done) begin
         khz_in = div_quo;
      end

      if (state_ff == tsc_pkg::ST_MUL && mul_done) begin
         offset_in = mul_hi;
      end

      if (state_ff == tsc_pkg::ST_NORM && norm_done) begin
         sec_in  = sec_ff + W'(norm_carry);
         nsec_in = norm_nsec;
      end

      // hold the result until the transfer; drop valid once taken
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tsc_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
         last_ff      <= '0;
         quot_ff      <= '0;
         sec_ff       <= '0;
         nsec_ff      <= '0;
         jiffy_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         last_ff      <= last_in;
         quot_ff      <= quot_in;
         sec_ff       <= sec_in;
         nsec_ff      <= nsec_in;
         jiffy_ff     <= jiffy_in;
      end
   end

   always_ff @(posedge clock) begin
      offset_ff <= offset_in;
      khz_ff    <= khz_in;
      status_ff <= status_in;
      if (out_load) begin
         out_sec_ff    <= sec_ff;
         out_nsec_ff   <= nsec_ff;
         out_jiffy_ff  <= jiffy_ff;
         out_offset_ff <= offset_ff;
         out_quot_ff   <= quot_ff;
         out_khz_ff    <= khz_ff;
         out_status_ff <= status_ff;
      end
   end

   // ------------------------------------------------------------------- units
   tsc_serial_div u_div (
      .clock    (clock),
      .reset    (reset),
      .req      (div_req),
      .done     (div_done),
      .quotient (div_quo)
   );

   tsc_serial_mul u_mul (
      .clock        (clock),
      .reset        (reset),
      .req          (mul_req),
      .done         (mul_done),
      .product_high (mul_hi)
   );

   tsc_ns_norm u_norm (
      .clock     (clock),
      .reset     (reset),
      .req       (norm_req),
      .done      (norm_done),
      .sec_carry (norm_carry),
      .nsec_out  (norm_nsec)
   );

   assign rsp_valid         = out_valid_ff;
   assign rsp_seconds       = out_sec_ff;
   assign rsp_nanoseconds   = out_nsec_ff;
   assign rsp_tick_total    = out_jiffy_ff;
   assign rsp_offset_us     = out_offset_ff;
   assign rsp_rate_quotient = out_quot_ff;
   assign rsp_cpu_khz       = out_khz_ff;
   assign rsp_cal_status    = out_status_ff;

   // -------------------------------------------------------------- assertions
   a_div_done_in_div : assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == tsc_pkg::ST_CAL_DIV || state_ff == tsc_pkg::ST_KHZ_DIV))
      else $error("divider finished outside a division state");

   a_norm_after_mul : assert property (@(posedge clock) disable iff (reset)
      norm_done |-> (state_ff == tsc_pkg::ST_NORM))
      else $error("normalizer finished outside its state");

   a_nsec_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({12'd0, rsp_nanoseconds} < tsc_pkg::NS_PER_SEC))
      else $error("nanoseconds not normalized");

   a_reject_clears : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_cal_status != CAL_OK) |-> (rsp_rate_quotient == '0 && rsp_cpu_khz == '0))
      else $error("rejected calibration left a quotient");

   a_no_new_during_work : assert property (@(posedge clock) disable iff (reset)
      (state_ff == tsc_pkg::ST_MUL) |=> (state_ff == tsc_pkg::ST_MUL || state_ff == tsc_pkg::ST_NORM))
      else $error("tick left the multiply step early");

endmodule

[hdl/tsc_serial_div.sv]
// ----------------------------------------------------------------------------
// tsc_serial_div
// Restoring divider, one quotient bit per cycle: (rem_init << 32) / divisor
// with rem_init below divisor.
// ----------------------------------------------------------------------------
module tsc_serial_div (
   input  logic                       clock,
   input  logic                       reset,
   input  tsc_pkg::div_req_type       req,
   output logic                       done,
   output logic [tsc_pkg::WORD_W-1:0] quotient
);

   localparam int unsigned W  = tsc_pkg::WORD_W;
   localparam int unsigned CW = $clog2(W);

   logic [W-1:0]  rem_ff, rem_in, dvs_ff, dvs_in, quo_ff, quo_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          run_ff, run_in, done_ff, done_in;
   logic [W:0]    shifted, diff;
   logic          ge;

   always_comb begin
      shifted = {rem_ff, 1'b0};
      diff    = shifted - {1'b0, dvs_ff};
      ge      = (shifted >= {1'b0, dvs_ff});

      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;

      if (req.start) begin
         rem_in = req.rem_init;
         dvs_in = req.divisor;
         quo_in = '0;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         // remainder stays below divisor, so it fits the word
         rem_in = ge ? diff[W-1:0] : shifted[W-1:0];
         quo_in = {quo_ff[W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

[hdl/tsc_serial_mul.sv]
// ----------------------------------------------------------------------------
// tsc_serial_mul
// Shift-add multiplier, one multiplicand bit per cycle; returns the high
// word of the 64-bit product.
// ----------------------------------------------------------------------------
module tsc_serial_mul (
   input  logic                       clock,
   input  logic                       reset,
   input  tsc_pkg::mul_req_type       req,
   output logic                       done,
   output logic [tsc_pkg::WORD_W-1:0] product_high
);

   localparam int unsigned W  = tsc_pkg::WORD_W;
   localparam int unsigned CW = $clog2(W);

   logic [W-1:0]  hi_ff, hi_in, mlr_ff, mlr_in, fac_ff, fac_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          run_ff, run_in, done_ff, done_in;
   logic [W:0]    sum;

   always_comb begin
      sum = {1'b0, hi_ff} + (mlr_ff[0] ? {1'b0, fac_ff} : '0);

      hi_in   = hi_ff;
      mlr_in  = mlr_ff;
      fac_in  = fac_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;

      if (req.start) begin
         hi_in  = '0;
         mlr_in = req.multiplicand;
         fac_in = req.factor;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         // shift the partial product right; low bits fall into the multiplier
         hi_in  = sum[W:1];
         mlr_in = {sum[0], mlr_ff[W-1:1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      hi_ff  <= hi_in;
      mlr_ff <= mlr_in;
      fac_ff <= fac_in;
   end

   assign done         = done_ff;
   assign product_high = hi_ff;

endmodule

[hdl/tsc_ns_norm.sv]
// ----------------------------------------------------------------------------
// tsc_ns_norm
// Adds offset * 1000 to the nanosecond count bit-serially, then splits the
// sum into whole seconds and a remainder below one second.
// ----------------------------------------------------------------------------
module tsc_ns_norm (
   input  logic                       clock,
   input  logic                       reset,
   input  tsc_pkg::norm_req_type      req,
   output logic                       done,
   output logic [tsc_pkg::SECQ_W-1:0] sec_carry,
   output logic [tsc_pkg::NSEC_W-1:0] nsec_out
);

   localparam int unsigned AW  = tsc_pkg::ACC_W;
   localparam int unsigned QW  = tsc_pkg::SECQ_W;
   localparam int unsigned KW  = tsc_pkg::USK_W;
   localparam int unsigned CW  = $clog2(QW);

   logic [AW-1:0] acc_ff, acc_in, mcd_ff, mcd_in, dvs_ff, dvs_in;
   logic [KW-1:0] kb_ff, kb_in;
   logic [QW-1:0] q_ff, q_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          run_ff, run_in, div_ph_ff, div_ph_in, done_ff, done_in;
   logic          ge;

   always_comb begin
      ge = (acc_ff >= dvs_ff);

      acc_in    = acc_ff;
      mcd_in    = mcd_ff;
      dvs_in    = dvs_ff;
      kb_in     = kb_ff;
      q_in      = q_ff;
      cnt_in    = cnt_ff;
      run_in    = run_ff;
      div_ph_in = div_ph_ff;
      done_in   = 1'b0;

      if (req.start) begin
         acc_in    = AW'(req.nsec);
         mcd_in    = AW'(req.offset);
         kb_in     = tsc_pkg::NS_PER_US;
         dvs_in    = tsc_pkg::NS_PER_SEC << (QW - 1);
         q_in      = '0;
         cnt_in    = '0;
         run_in    = 1'b1;
         div_ph_in = 1'b0;
      end else if (run_ff && !div_ph_ff) begin
         // multiply by the constant, one of its bits per cycle
         if (kb_ff[0]) begin
            acc_in = acc_ff + mcd_ff;
         end
         mcd_in = mcd_ff << 1;
         kb_in  = kb_ff >> 1;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(KW - 1)) begin
            cnt_in    = '0;
            div_ph_in = 1'b1;
         end
      end else if (run_ff) begin
         // restoring divide by one second, top quotient bit first
         if (ge) begin
            acc_in = acc_ff - dvs_ff;
         end
         q_in   = {q_ff[QW-2:0], ge};
         dvs_in = dvs_ff >> 1;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(QW - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff    <= 1'b0;
         div_ph_ff <= 1'b0;
         done_ff   <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         run_ff    <= run_in;
         div_ph_ff <= div_ph_in;
         done_ff   <= done_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      mcd_ff <= mcd_in;
      dvs_ff <= dvs_in;
      kb_ff  <= kb_in;
      q_ff   <= q_in;
   end

   assign done      = done_ff;
   assign sec_carry = q_ff;
   assign nsec_out  = acc_ff[tsc_pkg::NSEC_W-1:0];

endmodule
